### design/assert_macros.svh
// Assertion helpers used by the tq_ctrl RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/tq_pkg.sv
// ----------------------------------------------------------------------------
// tq_pkg
// Types, constants and helpers of the timed event queue.
// ----------------------------------------------------------------------------
package tq_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int PHASE_COUNT = 8;
	localparam int GROUP_COUNT = 8;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(TABLE_DEPTH);

	localparam logic [3:0] MODE_ADVANCE   = 4'd0;
	localparam logic [3:0] MODE_SCHEDULE  = 4'd1;
	localparam logic [3:0] MODE_RESCHED   = 4'd2;
	localparam logic [3:0] MODE_CANCEL_ID = 4'd3;
	localparam logic [3:0] MODE_CANCEL_GR = 4'd4;
	localparam logic [3:0] MODE_SET_PH    = 4'd5;
	localparam logic [3:0] MODE_ADD_PH    = 4'd6;
	localparam logic [3:0] MODE_REM_PH    = 4'd7;
	localparam logic [3:0] MODE_POP       = 4'd8;
	localparam logic [3:0] MODE_PEEK      = 4'd9;
	localparam logic [3:0] MODE_REPEAT    = 4'd10;
	localparam logic [3:0] MODE_PULL      = 4'd11;
	localparam logic [3:0] MODE_DELAY_GR  = 4'd12;
	localparam logic [3:0] MODE_DELAY_ID  = 4'd13;
	localparam logic [3:0] MODE_QUERY     = 4'd14;

	typedef struct packed {
		logic [31:0] due;
		logic [15:0] event_id;
		logic [7:0]  groups;
		logic [7:0]  phases;
	} tq_entry_t;

	localparam int ENTRY_W = $bits(tq_entry_t);

	typedef struct packed {
		logic [15:0] result_event;
		logic        found;
		logic [31:0] due_time_out;
		logic [31:0] clock_now;
		logic [7:0]  phase_mask_out;
		logic        table_empty;
		logic        status;
	} tq_result_t;

	function automatic logic [7:0] phase_bit(input logic [3:0] n);
		logic [7:0] r;
		r = '0;
		if (n >= 4'd1 && n <= 4'(PHASE_COUNT))
			r = 8'(1) << (n - 4'd1);
		return r;
	endfunction

	function automatic logic [7:0] group_bit(input logic [3:0] n);
		logic [7:0] r;
		r = '0;
		if (n >= 4'd1 && n <= 4'(GROUP_COUNT))
			r = 8'(1) << (n - 4'd1);
		return r;
	endfunction

endpackage

### design/tq_ram.sv
// ----------------------------------------------------------------------------
// tq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

### design/tq_ctrl.sv
// ----------------------------------------------------------------------------
// tq_ctrl
// Sequencer and shared scan unit: walks the entry RAM one entry a cycle for
// minimum, match, mark and collision passes, and carries out each operation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [3:0]          mode,
	input  logic [15:0]         event_id,
	input  logic [31:0]         time_value,
	input  logic [3:0]          group_number,
	input  logic [3:0]          phase_number,
	output logic                idle,
	output logic                res_valid,
	input  logic                res_take,
	output tq_pkg::tq_result_t  res
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_POST  = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	localparam logic [2:0] SC_MIN     = 3'd0;
	localparam logic [2:0] SC_MINID   = 3'd1;
	localparam logic [2:0] SC_MINMARK = 3'd2;
	localparam logic [2:0] SC_CANC_ID = 3'd3;
	localparam logic [2:0] SC_CANC_GR = 3'd4;
	localparam logic [2:0] SC_MARK    = 3'd5;
	localparam logic [2:0] SC_PROBE   = 3'd6;

	logic [2:0]  state_q, scan_q;
	logic [tq_pkg::TABLE_DEPTH-1:0] valid_q, mark_q;
	logic [31:0] clock_q, limit_q, tv_q;
	logic [7:0]  phase_q, gm_q;
	logic [3:0]  mode_q;
	logic [15:0] id_q;

	logic [tq_pkg::CNT_W-1:0] iss_q;
	logic                     rvalid_s1;
	logic [tq_pkg::IDX_W-1:0] ridx_s1;

	tq_pkg::tq_entry_t        ins_q;
	logic [tq_pkg::IDX_W-1:0] slot_q;
	logic                     free_found_q, dirty_q;

	logic                     min_found_q;
	logic [tq_pkg::IDX_W-1:0] min_idx_q;
	tq_pkg::tq_entry_t        min_q;

	logic [15:0] res_event_q;
	logic [31:0] due_out_q;
	logic        found_q, status_q;

	logic [tq_pkg::ENTRY_W-1:0] rdata;
	tq_pkg::tq_entry_t          rd;
	logic                       ram_we;
	logic                       cand, better, hit, scan_last, drop;

	assign rd        = tq_pkg::tq_entry_t'(rdata);
	assign ram_we    = (state_q == S_WRITE);
	assign scan_last = rvalid_s1 && (ridx_s1 == tq_pkg::IDX_LAST);
	assign better    = !min_found_q || (rd.due < min_q.due);
	assign hit       = (mode_q == tq_pkg::MODE_DELAY_ID) ? (rd.event_id == id_q)
	                                                     : ((rd.groups & gm_q) != 8'd0);
	assign drop      = (phase_q != 8'd0) && (min_q.phases != 8'd0) &&
	                   ((min_q.phases & phase_q) == 8'd0);

	always_comb begin
		case (scan_q)
			SC_MIN:     cand = valid_q[ridx_s1];
			SC_MINID:   cand = valid_q[ridx_s1] && (rd.event_id == id_q);
			SC_MINMARK: cand = mark_q[ridx_s1];
			default:    cand = 1'b0;
		endcase
	end

	tq_ram #(
		.WIDTH(tq_pkg::ENTRY_W),
		.DEPTH(tq_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(ins_q),
		.raddr(iss_q[tq_pkg::IDX_W-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			scan_q       <= SC_MIN;
			valid_q      <= '0;
			mark_q       <= '0;
			clock_q      <= '0;
			phase_q      <= '0;
			iss_q        <= '0;
			rvalid_s1    <= 1'b0;
			free_found_q <= 1'b0;
			dirty_q      <= 1'b0;
			min_found_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q      <= mode;
						id_q        <= event_id;
						tv_q        <= time_value;
						gm_q        <= tq_pkg::group_bit(group_number);
						limit_q     <= clock_q + time_value;
						ins_q       <= '{due: clock_q + time_value, event_id: event_id,
						                 groups: tq_pkg::group_bit(group_number),
						                 phases: tq_pkg::phase_bit(phase_number)};
						res_event_q <= '0;
						found_q     <= 1'b0;
						due_out_q   <= '0;
						status_q    <= 1'b0;
						iss_q       <= '0;
						min_found_q <= 1'b0;
						dirty_q     <= 1'b0;
						free_found_q <= 1'b0;
						state_q     <= S_SCAN;
						case (mode)
							tq_pkg::MODE_ADVANCE: begin
								clock_q <= clock_q + time_value;
								state_q <= S_DONE;
							end
							tq_pkg::MODE_SCHEDULE: scan_q <= SC_PROBE;
							tq_pkg::MODE_RESCHED, tq_pkg::MODE_CANCEL_ID: scan_q <= SC_CANC_ID;
							tq_pkg::MODE_CANCEL_GR: scan_q <= SC_CANC_GR;
							tq_pkg::MODE_SET_PH: begin
								if (phase_number == 4'd0)
									phase_q <= '0;
								else if (phase_number <= 4'(tq_pkg::PHASE_COUNT))
									phase_q <= tq_pkg::phase_bit(phase_number);
								state_q <= S_DONE;
							end
							tq_pkg::MODE_ADD_PH: begin
								phase_q <= phase_q | tq_pkg::phase_bit(phase_number);
								state_q <= S_DONE;
							end
							tq_pkg::MODE_REM_PH: begin
								phase_q <= phase_q & ~tq_pkg::phase_bit(phase_number);
								state_q <= S_DONE;
							end
							tq_pkg::MODE_POP, tq_pkg::MODE_PEEK, tq_pkg::MODE_REPEAT:
								scan_q <= SC_MIN;
							tq_pkg::MODE_PULL: begin
								clock_q <= (time_value < clock_q) ? clock_q - time_value : '0;
								state_q <= S_DONE;
							end
							tq_pkg::MODE_DELAY_GR, tq_pkg::MODE_DELAY_ID: scan_q <= SC_MARK;
							tq_pkg::MODE_QUERY: scan_q <= SC_MINID;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					if (iss_q < tq_pkg::CNT_DEPTH) begin
						rvalid_s1 <= 1'b1;
						ridx_s1   <= iss_q[tq_pkg::IDX_W-1:0];
						iss_q     <= iss_q + 1'b1;
					end else begin
						rvalid_s1 <= 1'b0;
					end
					if (rvalid_s1) begin
						if (cand && better) begin
							min_found_q <= 1'b1;
							min_idx_q   <= ridx_s1;
							min_q       <= rd;
						end
						case (scan_q)
							SC_CANC_ID:
								if (rd.event_id == id_q)
									valid_q[ridx_s1] <= 1'b0;
							SC_CANC_GR:
								if ((rd.groups & gm_q) != 8'd0)
									valid_q[ridx_s1] <= 1'b0;
							SC_MARK:
								mark_q[ridx_s1] <= valid_q[ridx_s1] && (rd.due < limit_q) && hit;
							SC_PROBE: begin
								if (!valid_q[ridx_s1]) begin
									if (!free_found_q) begin
										free_found_q <= 1'b1;
										slot_q       <= ridx_s1;
									end
								end else if (rd.due == ins_q.due) begin
									// collision: bump and force another clean pass
									ins_q.due <= ins_q.due + 32'd1;
									dirty_q   <= 1'b1;
								end
							end
							default: ;
						endcase
					end
					if (scan_last)
						state_q <= S_POST;
				end
				S_POST: begin
					iss_q        <= '0;
					min_found_q  <= 1'b0;
					dirty_q      <= 1'b0;
					free_found_q <= 1'b0;
					state_q      <= S_SCAN;
					case (scan_q)
						SC_CANC_ID:
							if (mode_q == tq_pkg::MODE_RESCHED)
								scan_q <= SC_PROBE;
							else
								state_q <= S_DONE;
						SC_PROBE: begin
							if (!free_found_q) begin
								status_q <= 1'b1;
								state_q  <= S_DONE;
							end else if (!dirty_q) begin
								state_q <= S_WRITE;
							end
						end
						SC_MIN: begin
							if (mode_q == tq_pkg::MODE_REPEAT) begin
								if (min_found_q) begin
									valid_q[min_idx_q] <= 1'b0;
									ins_q     <= min_q;
									ins_q.due <= clock_q + tv_q;
									scan_q    <= SC_PROBE;
								end else begin
									state_q <= S_DONE;
								end
							end else if (!min_found_q || min_q.due > clock_q) begin
								state_q <= S_DONE;
							end else if (drop) begin
								valid_q[min_idx_q] <= 1'b0;
							end else begin
								res_event_q <= min_q.event_id;
								found_q     <= 1'b1;
								if (mode_q == tq_pkg::MODE_POP)
									valid_q[min_idx_q] <= 1'b0;
								state_q <= S_DONE;
							end
						end
						SC_MINID: begin
							found_q   <= min_found_q;
							due_out_q <= min_found_q ? min_q.due : '0;
							state_q   <= S_DONE;
						end
						SC_MARK: scan_q <= SC_MINMARK;
						SC_MINMARK: begin
							if (min_found_q) begin
								mark_q[min_idx_q]  <= 1'b0;
								valid_q[min_idx_q] <= 1'b0;
								ins_q     <= min_q;
								ins_q.due <= min_q.due + tv_q;
								scan_q    <= SC_PROBE;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_WRITE: begin
					valid_q[slot_q] <= 1'b1;
					if (mode_q == tq_pkg::MODE_DELAY_GR || mode_q == tq_pkg::MODE_DELAY_ID) begin
						iss_q       <= '0;
						min_found_q <= 1'b0;
						scan_q      <= SC_MINMARK;
						state_q     <= S_SCAN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.result_event   = res_event_q;
		res.found          = found_q;
		res.due_time_out   = due_out_q;
		res.clock_now      = clock_q;
		res.phase_mask_out = phase_q;
		res.table_empty    = (valid_q == '0);
		res.status         = status_q;
	end

	`TQ_ASSERT_IMP(a_write_free_slot, ram_we, !valid_q[slot_q], "insert overwrote a live entry")
	`TQ_ASSERT_NXT(a_start_busy, start && idle, !idle, "accepted beat did not start work")
	`TQ_ASSERT_NXT(a_done_hold, res_valid && !res_take, res_valid, "result dropped before taken")

endmodule

### design/timed_event_queue.sv
// ----------------------------------------------------------------------------
// timed_event_queue
// Timed event queue with phase mask: 32-entry table, clock and phase state.
// ----------------------------------------------------------------------------
// Each beat is one operation and yields one result beat. Clock and phase
// operations go straight from the idle state to the done state. Every table
// operation runs full passes over the entry RAM, one entry read per cycle:
// cancel and query take one pass, pop and peek one pass plus one per
// dropped inactive entry, schedule one pass plus one more for every pass that
// bumped the due time, and a write step, reschedule a cancel pass ahead of
// that, repeat one minimum pass plus, if it finds an entry, the schedule passes,
// and delay one mark pass plus, for each moved entry, a minimum pass and an
// insert, plus a last minimum pass that finds nothing. in_ready is high only
// while the sequencer is idle; a finished result sits in the output register
// so the next beat can be taken while it waits.
module timed_event_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  mode,
	input  logic [15:0] event_id,
	input  logic [31:0] time_value,
	input  logic [3:0]  group_number,
	input  logic [3:0]  phase_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result_event,
	output logic        found,
	output logic [31:0] due_time_out,
	output logic [31:0] clock_now,
	output logic [7:0]  phase_mask_out,
	output logic        table_empty,
	output logic        status
);

	logic               idle, res_valid, res_take;
	tq_pkg::tq_result_t res, out_q;
	logic               out_valid_q;

	assign in_ready = idle;
	assign res_take = res_valid && (!out_valid_q || out_ready);

	tq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_valid && in_ready),
		.mode        (mode),
		.event_id    (event_id),
		.time_value  (time_value),
		.group_number(group_number),
		.phase_number(phase_number),
		.idle        (idle),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take)
			out_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign result_event   = out_q.result_event;
	assign found          = out_q.found;
	assign due_time_out   = out_q.due_time_out;
	assign clock_now      = out_q.clock_now;
	assign phase_mask_out = out_q.phase_mask_out;
	assign table_empty    = out_q.table_empty;
	assign status         = out_q.status;

endmodule
